>>> rtl/brsp_pkg.sv
// Shared constants and types for the bus RAM with serial port.
package brsp_pkg;

    localparam int MEM_BYTES = 65536;
    localparam int ADDR_W    = $clog2(MEM_BYTES);

    localparam logic [7:0] IO_PAGE_RESET = 8'hE0;
    localparam logic [7:0] OFS_DATA      = 8'h00;
    localparam logic [7:0] OFS_STATUS    = 8'h01;

    localparam int PADDR_W = 3;
    localparam logic REG_IO_PAGE = 1'b0;

    typedef enum logic [1:0] {
        FUNC_READ    = 2'd0,
        FUNC_WRITE   = 2'd1,
        FUNC_HOST_RX = 2'd2,
        FUNC_HOST_TX = 2'd3
    } t_func;

    typedef struct packed {
        logic accept;
        logic load_out;
    } t_cmd;

endpackage

>>> rtl/bus_ram_with_serial_port.sv
// Top level: byte-wide bus RAM with a one-byte serial receive/transmit port.
//
// Input channel (i_valid/o_ready) carries one operation per item: i_func
// 0 bus read, 1 bus write, 2 host offers a received byte, 3 host takes the
// pending transmit byte; i_address and i_data as the operation needs.
// Output channel (o_valid/i_ready) returns exactly one result per item:
// read data, transmit byte with its valid flag, and receive acceptance.
// The serial data (offset 0) and status (offset 1) registers sit in the
// 256-byte page named by io_page, written through the APB port at
// address 0 (reset 0xE0).
// An accepted item goes through the synchronous RAM access and the staging
// registers, then is loaded into the output register once that register is
// free; no new item is accepted until that load.
// If the receiver stalls, the result waits in the output register while
// the next item is accepted; that item then holds until the register frees.
// Reset clears the serial flags, the output valid and restores io_page;
// RAM contents are undefined until written.
module bus_ram_with_serial_port (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [1:0]                   i_func,
    input  logic [15:0]                  i_address,
    input  logic [7:0]                   i_data,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [7:0]                   o_read_data,
    output logic [7:0]                   o_tx_byte,
    output logic                         o_tx_valid,
    output logic                         o_rx_accepted,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [brsp_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);

    brsp_pkg::t_cmd cmd;
    logic           cfg_we;
    logic [7:0]     io_page;

    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite
                    && (paddr[brsp_pkg::PADDR_W-1] == brsp_pkg::REG_IO_PAGE);
    assign prdata = (paddr[brsp_pkg::PADDR_W-1] == brsp_pkg::REG_IO_PAGE)
                    ? {24'd0, io_page} : 32'd0;

    brsp_ctrl u_ctrl (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .i_ready(i_ready),
        .o_ready(o_ready),
        .o_valid(o_valid),
        .o_cmd  (cmd)
    );

    brsp_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_func       (i_func),
        .i_address    (i_address),
        .i_data       (i_data),
        .i_cfg_we     (cfg_we),
        .i_cfg_wdata  (pwdata[7:0]),
        .o_io_page    (io_page),
        .o_read_data  (o_read_data),
        .o_tx_byte    (o_tx_byte),
        .o_tx_valid   (o_tx_valid),
        .o_rx_accepted(o_rx_accepted)
    );

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("input accepted twice in a row");

    a_one_side: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_tx_valid && o_rx_accepted))
        else $error("transmit and receive flagged in one item");

    a_tx_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_tx_valid |-> o_tx_byte == 8'd0)
        else $error("transmit byte without valid");

    a_rd_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_tx_valid || o_rx_accepted) |-> o_read_data == 8'd0)
        else $error("read data on a host item");

endmodule

>>> rtl/brsp_ram.sv
// Generic single-port RAM with registered read.
module brsp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/brsp_ctrl.sv
// Item sequencing state machine and output valid tracking.
module brsp_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  logic          i_ready,
    output logic          o_ready,
    output logic          o_valid,
    output brsp_pkg::t_cmd o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   out_free;

    assign out_free = !r_out_valid || i_ready;

    always_comb begin
        n_state         = r_state;
        n_out_valid     = r_out_valid && !i_ready;
        o_cmd.accept    = 1'b0;
        o_cmd.load_out  = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_EXEC;
                end
            end
            S_EXEC: begin
                if (out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = r_out_valid;

endmodule

>>> rtl/brsp_dp.sv
// Datapath: RAM, serial holding registers, page register and output register.
module brsp_dp (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  brsp_pkg::t_cmd           i_cmd,
    input  logic [1:0]               i_func,
    input  logic [15:0]              i_address,
    input  logic [7:0]               i_data,
    input  logic                     i_cfg_we,
    input  logic [7:0]               i_cfg_wdata,
    output logic [7:0]               o_io_page,
    output logic [7:0]               o_read_data,
    output logic [7:0]               o_tx_byte,
    output logic                     o_tx_valid,
    output logic                     o_rx_accepted
);

    logic [7:0] r_io_page;
    logic       r_rx_full, n_rx_full;
    logic       r_tx_full, n_tx_full;
    logic [7:0] r_rx_hold, n_rx_hold;
    logic [7:0] r_tx_hold, n_tx_hold;

    logic       r_sel_ram, n_sel_ram;
    logic [7:0] r_io_val, n_io_val;
    logic [7:0] r_txb, n_txb;
    logic       r_txv, n_txv;
    logic       r_rxa, n_rxa;

    logic [7:0] r_out_rd, r_out_txb;
    logic       r_out_txv, r_out_rxa;

    logic       in_page;
    logic [7:0] ofs;
    logic       ram_we, ram_re;
    logic [7:0] ram_rdata;

    assign in_page = (i_address[15:8] == r_io_page);
    assign ofs     = i_address[7:0];

    always_comb begin
        n_rx_full = r_rx_full;
        n_tx_full = r_tx_full;
        n_rx_hold = r_rx_hold;
        n_tx_hold = r_tx_hold;
        n_sel_ram = 1'b0;
        n_io_val  = 8'd0;
        n_txb     = 8'd0;
        n_txv     = 1'b0;
        n_rxa     = 1'b0;
        ram_we    = 1'b0;
        ram_re    = 1'b0;
        case (brsp_pkg::t_func'(i_func))
            brsp_pkg::FUNC_READ: begin
                if (!in_page) begin
                    n_sel_ram = 1'b1;
                    ram_re    = i_cmd.accept;
                end else if (ofs == brsp_pkg::OFS_STATUS) begin
                    n_io_val = {6'd0, !r_tx_full, r_rx_full};
                end else if (ofs == brsp_pkg::OFS_DATA) begin
                    n_io_val  = r_rx_full ? r_rx_hold : 8'd0;
                    n_rx_full = 1'b0;
                end
            end
            brsp_pkg::FUNC_WRITE: begin
                if (in_page && ofs == brsp_pkg::OFS_DATA) begin
                    if (!r_tx_full) begin
                        n_tx_hold = i_data;
                        n_tx_full = 1'b1;
                    end
                end else begin
                    ram_we = i_cmd.accept;
                end
            end
            brsp_pkg::FUNC_HOST_RX: begin
                if (!r_rx_full) begin
                    n_rx_hold = i_data;
                    n_rx_full = 1'b1;
                    n_rxa     = 1'b1;
                end
            end
            brsp_pkg::FUNC_HOST_TX: begin
                if (r_tx_full) begin
                    n_txb     = r_tx_hold;
                    n_txv     = 1'b1;
                    n_tx_full = 1'b0;
                end
            end
            default: begin
                n_sel_ram = 1'b0;
            end
        endcase
    end

    brsp_ram #(
        .WIDTH(8),
        .DEPTH(brsp_pkg::MEM_BYTES)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_re   (ram_re),
        .i_addr (i_address[brsp_pkg::ADDR_W-1:0]),
        .i_wdata(i_data),
        .o_rdata(ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_io_page <= brsp_pkg::IO_PAGE_RESET;
            r_rx_full <= 1'b0;
            r_tx_full <= 1'b0;
            r_rx_hold <= 8'd0;
            r_tx_hold <= 8'd0;
        end else begin
            if (i_cfg_we) begin
                r_io_page <= i_cfg_wdata;
            end
            if (i_cmd.accept) begin
                r_rx_full <= n_rx_full;
                r_tx_full <= n_tx_full;
                r_rx_hold <= n_rx_hold;
                r_tx_hold <= n_tx_hold;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_sel_ram <= n_sel_ram;
            r_io_val  <= n_io_val;
            r_txb     <= n_txb;
            r_txv     <= n_txv;
            r_rxa     <= n_rxa;
        end
        if (i_cmd.load_out) begin
            r_out_rd  <= r_sel_ram ? ram_rdata : r_io_val;
            r_out_txb <= r_txb;
            r_out_txv <= r_txv;
            r_out_rxa <= r_rxa;
        end
    end

    assign o_io_page     = r_io_page;
    assign o_read_data   = r_out_rd;
    assign o_tx_byte     = r_out_txb;
    assign o_tx_valid    = r_out_txv;
    assign o_rx_accepted = r_out_rxa;

endmodule

>>> dv/tb_bus_ram_with_serial_port.sv
`timescale 1ns / 100ps
// Self-checking testbench for bus_ram_with_serial_port with directed and random items.
module tb_bus_ram_with_serial_port;

    typedef struct packed {
        brsp_pkg::t_func func;
        logic [15:0]     addr;
        logic [7:0]      data;
    } t_bus_op;

    typedef struct packed {
        logic [7:0] rd;
        logic [7:0] txb;
        logic       txv;
        logic       rxa;
    } t_bus_resp;

    logic                         i_clk = 1'b0;
    logic                         i_rst_n = 1'b0;
    logic                         i_valid = 1'b0;
    logic                         o_ready;
    logic [1:0]                   i_func = '0;
    logic [15:0]                  i_address = '0;
    logic [7:0]                   i_data = '0;
    logic                         o_valid;
    logic                         i_ready = 1'b0;
    logic [7:0]                   o_read_data;
    logic [7:0]                   o_tx_byte;
    logic                         o_tx_valid;
    logic                         o_rx_accepted;
    logic                         psel = 1'b0;
    logic                         penable = 1'b0;
    logic                         pwrite = 1'b0;
    logic [brsp_pkg::PADDR_W-1:0] paddr = '0;
    logic [31:0]                  pwdata = '0;
    logic [31:0]                  prdata;
    logic                         pready;

    bus_ram_with_serial_port dut (.*);

    // expected state
    logic [7:0] mem_img [0:brsp_pkg::MEM_BYTES-1];
    logic [7:0] rx_hold = '0;
    logic [7:0] tx_hold = '0;
    logic       rx_busy = 1'b0;
    logic       tx_busy = 1'b0;
    logic [7:0] cur_page = brsp_pkg::IO_PAGE_RESET;

    // stimulus bookkeeping
    bit        ram_seen [0:brsp_pkg::MEM_BYTES-1];
    int        seen_list[$];
    t_bus_op   op_q[$];
    t_bus_resp resp_q[$];
    int        n_queued = 0;
    int        n_checked = 0;
    int        n_fail = 0;

    bit        item_taken = 1'b0;
    int        burst_left = 1;
    int        gap_left = 0;
    int        rcv_cyc = 0;
    t_bus_op   drv_op;
    t_bus_op   mon_op;
    t_bus_resp want;

    function automatic t_bus_resp serial_bus_step(t_bus_op op);
        t_bus_resp r;
        logic      in_page;
        r = '0;
        in_page = (op.addr[15:8] == cur_page);
        case (op.func)
            brsp_pkg::FUNC_READ: begin
                if (!in_page) begin
                    r.rd = mem_img[op.addr];
                end else if (op.addr[7:0] == brsp_pkg::OFS_STATUS) begin
                    r.rd = {6'd0, !tx_busy, rx_busy};
                end else if (op.addr[7:0] == brsp_pkg::OFS_DATA) begin
                    r.rd = rx_busy ? rx_hold : 8'h00;
                    rx_busy = 1'b0;
                end
            end
            brsp_pkg::FUNC_WRITE: begin
                if (in_page && op.addr[7:0] == brsp_pkg::OFS_DATA) begin
                    if (!tx_busy) begin
                        tx_hold = op.data;
                        tx_busy = 1'b1;
                    end
                end else begin
                    mem_img[op.addr] = op.data;
                end
            end
            brsp_pkg::FUNC_HOST_RX: begin
                if (!rx_busy) begin
                    rx_hold = op.data;
                    rx_busy = 1'b1;
                    r.rxa   = 1'b1;
                end
            end
            default: begin
                if (tx_busy) begin
                    r.txb   = tx_hold;
                    r.txv   = 1'b1;
                    tx_busy = 1'b0;
                end
            end
        endcase
        return r;
    endfunction

    // reads outside the serial page only ever hit bytes already written
    task automatic queue_op(brsp_pkg::t_func f, logic [15:0] a, logic [7:0] d);
        t_bus_op op;
        op.func = f;
        op.addr = a;
        op.data = d;
        if (f == brsp_pkg::FUNC_WRITE
            && !(a[15:8] == cur_page && a[7:0] == brsp_pkg::OFS_DATA)
            && !ram_seen[a]) begin
            ram_seen[a] = 1'b1;
            seen_list.push_back(int'(a));
        end
        op_q.push_back(op);
        n_queued++;
    endtask

    task automatic queue_random_op();
        int unsigned pick;
        logic [15:0] a;
        logic [7:0]  d;
        pick = $urandom_range(0, 99);
        a    = 16'($urandom);
        d    = 8'($urandom);
        if (pick < 20) begin
            queue_op(brsp_pkg::FUNC_HOST_RX, a, d);
        end else if (pick < 35) begin
            queue_op(brsp_pkg::FUNC_HOST_TX, a, d);
        end else if (pick < 45) begin
            queue_op(brsp_pkg::FUNC_WRITE, {cur_page, brsp_pkg::OFS_DATA}, d);
        end else if (pick < 62) begin
            queue_op(brsp_pkg::FUNC_WRITE, a, d);
        end else if (pick < 66) begin
            queue_op(brsp_pkg::FUNC_WRITE, {cur_page, a[7:0]}, d);
        end else if (pick < 76) begin
            queue_op(brsp_pkg::FUNC_READ, {cur_page, brsp_pkg::OFS_DATA}, d);
        end else if (pick < 84) begin
            queue_op(brsp_pkg::FUNC_READ, {cur_page, brsp_pkg::OFS_STATUS}, d);
        end else if (pick < 87) begin
            queue_op(brsp_pkg::FUNC_READ, {cur_page, a[7:0]}, d);
        end else if (seen_list.size() > 0) begin
            queue_op(brsp_pkg::FUNC_READ,
                     16'(seen_list[$urandom_range(0, seen_list.size() - 1)]), d);
        end else begin
            queue_op(brsp_pkg::FUNC_READ, {cur_page, brsp_pkg::OFS_STATUS}, d);
        end
    endtask

    task automatic wait_drained();
        do @(negedge i_clk);
        while (n_checked < n_queued);
    endtask

    task automatic write_io_page(logic [7:0] page);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= brsp_pkg::PADDR_W'({brsp_pkg::REG_IO_PAGE, 2'b00});
        pwdata  <= {24'd0, page};
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        cur_page = page;
    endtask

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #3_000_000;
        $display("TEST FAILED");
        $finish;
    end

    // sender: bursts with random gaps
    always @(negedge i_clk) begin
        if (i_rst_n && (!i_valid || item_taken)) begin
            if (gap_left > 0) begin
                gap_left--;
                i_valid <= 1'b0;
            end else if (op_q.size() > 0) begin
                drv_op = op_q.pop_front();
                i_valid   <= 1'b1;
                i_func    <= drv_op.func;
                i_address <= drv_op.addr;
                i_data    <= drv_op.data;
                if (burst_left <= 1) begin
                    burst_left = $urandom_range(1, 40);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end else begin
                    burst_left--;
                end
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // receiver: always ready, random, or mostly stalled, in turn
    always @(negedge i_clk) begin
        rcv_cyc++;
        case ((rcv_cyc / 300) % 3)
            0:       i_ready <= 1'b1;
            1:       i_ready <= 1'($urandom_range(0, 1));
            default: i_ready <= (rcv_cyc % 5 == 0);
        endcase
    end

    always @(posedge i_clk) begin
        item_taken = i_rst_n && i_valid && o_ready;
        if (i_rst_n && o_valid && i_ready) begin
            if (resp_q.size() == 0) begin
                $error("result with no item pending");
                n_fail++;
            end else begin
                want = resp_q.pop_front();
                if (o_read_data !== want.rd) begin
                    $error("read_data: expected %0h, got %0h", want.rd, o_read_data);
                    n_fail++;
                end
                if (o_tx_byte !== want.txb) begin
                    $error("tx_byte: expected %0h, got %0h", want.txb, o_tx_byte);
                    n_fail++;
                end
                if (o_tx_valid !== want.txv) begin
                    $error("tx_valid: expected %0h, got %0h", want.txv, o_tx_valid);
                    n_fail++;
                end
                if (o_rx_accepted !== want.rxa) begin
                    $error("rx_accepted: expected %0h, got %0h", want.rxa, o_rx_accepted);
                    n_fail++;
                end
                n_checked++;
            end
        end
        if (item_taken) begin
            mon_op.func = brsp_pkg::t_func'(i_func);
            mon_op.addr = i_address;
            mon_op.data = i_data;
            resp_q.push_back(serial_bus_step(mon_op));
        end
    end

    initial begin
        logic [7:0] page;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // serial port and RAM address corner cases at the reset page
        queue_op(brsp_pkg::FUNC_READ,
                 {brsp_pkg::IO_PAGE_RESET, brsp_pkg::OFS_STATUS}, 8'h00);
        queue_op(brsp_pkg::FUNC_READ,
                 {brsp_pkg::IO_PAGE_RESET, brsp_pkg::OFS_DATA}, 8'h00);
        queue_op(brsp_pkg::FUNC_HOST_TX, 16'h0000, 8'h00);
        queue_op(brsp_pkg::FUNC_HOST_RX, 16'h0000, 8'h1C);
        queue_op(brsp_pkg::FUNC_HOST_RX, 16'hFFFF, 8'hFF);
        queue_op(brsp_pkg::FUNC_READ,
                 {brsp_pkg::IO_PAGE_RESET, brsp_pkg::OFS_STATUS}, 8'h00);
        queue_op(brsp_pkg::FUNC_READ,
                 {brsp_pkg::IO_PAGE_RESET, brsp_pkg::OFS_DATA}, 8'h00);
        queue_op(brsp_pkg::FUNC_READ,
                 {brsp_pkg::IO_PAGE_RESET, brsp_pkg::OFS_DATA}, 8'h00);
        queue_op(brsp_pkg::FUNC_WRITE,
                 {brsp_pkg::IO_PAGE_RESET, brsp_pkg::OFS_DATA}, 8'hA5);
        queue_op(brsp_pkg::FUNC_WRITE,
                 {brsp_pkg::IO_PAGE_RESET, brsp_pkg::OFS_DATA}, 8'h5A);
        queue_op(brsp_pkg::FUNC_READ,
                 {brsp_pkg::IO_PAGE_RESET, brsp_pkg::OFS_STATUS}, 8'h00);
        queue_op(brsp_pkg::FUNC_HOST_TX, 16'h0000, 8'h00);
        queue_op(brsp_pkg::FUNC_HOST_TX, 16'h0000, 8'h00);
        queue_op(brsp_pkg::FUNC_WRITE,
                 {brsp_pkg::IO_PAGE_RESET, brsp_pkg::OFS_STATUS}, 8'h77);
        queue_op(brsp_pkg::FUNC_WRITE, {brsp_pkg::IO_PAGE_RESET, 8'hFF}, 8'h81);
        queue_op(brsp_pkg::FUNC_READ,  {brsp_pkg::IO_PAGE_RESET, 8'hFF}, 8'h00);
        queue_op(brsp_pkg::FUNC_WRITE, 16'h0000, 8'h00);
        queue_op(brsp_pkg::FUNC_WRITE, 16'hFFFF, 8'hFF);
        queue_op(brsp_pkg::FUNC_READ,  16'hFFFF, 8'h00);
        queue_op(brsp_pkg::FUNC_READ,  16'h0000, 8'hFF);
        queue_op(brsp_pkg::FUNC_HOST_RX, 16'h0000, 8'h00);
        queue_op(brsp_pkg::FUNC_READ,
                 {brsp_pkg::IO_PAGE_RESET, brsp_pkg::OFS_DATA}, 8'h00);
        wait_drained();

        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                1:       page = 8'h00;
                2:       page = 8'hFF;
                4:       page = brsp_pkg::IO_PAGE_RESET;
                default: page = 8'($urandom);
            endcase
            if (ph > 0) begin
                write_io_page(page);
            end
            repeat (160) queue_random_op();
            wait_drained();
            repeat (160) queue_random_op();
            wait_drained();
        end

        repeat (8) @(posedge i_clk);
        if (resp_q.size() != 0) begin
            $error("%0d results never arrived", resp_q.size());
            n_fail++;
        end
        if (n_fail == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
